[rtl/core/assert_macros.svh]
// Assertion macros for the checker RTL.
// Included by modules that carry concurrent assertions; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Property must hold at every rising clock edge outside reset.
`define ASSERT_AT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_AT(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

[rtl/core/mpc_pkg.sv]
// Shared types and constants of the matrix product checker.
// No dependencies; imported by the top level, front and back parts of the block.
package mpc_pkg;

	localparam int MAX_DIM_DEF    = 16;
	localparam int ELEM_WIDTH_DEF = 16;
	localparam int FRAC_BITS      = 8;
	localparam int MAX_TRIALS     = 64;
	localparam logic [31:0] LFSR_TAPS = 32'h8020_0003;

	typedef enum logic [1:0] {
		CMD_LOAD_A = 2'd0,
		CMD_LOAD_B = 2'd1,
		CMD_LOAD_C = 2'd2,
		CMD_CHECK  = 2'd3
	} cmd_t;

	localparam logic [1:0] REG_SIZE   = 2'd0;
	localparam logic [1:0] REG_TRIALS = 2'd1;
	localparam logic [1:0] REG_SEED   = 2'd2;

	// Settings in force, already clamped to their legal ranges.
	typedef struct packed {
		logic [6:0]  dim;
		logic [6:0]  trials;
		logic        seed_we;
		logic [31:0] seed;
	} cfg_t;

endpackage

[rtl/core/matrix_product_checker.sv]
// Top level of the matrix product checker: configuration registers and
// wiring of front, queue and back. Uses mpc_pkg, mpc_front, mpc_queue, mpc_back.
//
// Usage: the slave stream carries one item per handshake. s_tuser holds the
// command (load A, load B, load C, run check); s_tdata holds row, column and
// a signed Q8.8 element. Loads produce no result. A check item produces one
// result item on the master stream: bit 0 says whether every trial found
// A*B equal to C, bits 7:1 count the trials that matched.
// Loads are taken at one item per cycle while the queue has room; each store
// write happens as the item is popped from the two-entry queue.
// Each trial of a check on an n by n problem is paced by the single read
// port of each element memory, which the back part walks one element per
// cycle, first for B*r and C*r, then for A*(B*r).
// Items keep arriving into the queue while a check runs, up to two entries.
// Reset clears the control state, restores size 16, trials 8 and seed 1,
// and reloads the random generator; matrix memories keep undefined contents.
// If the receiver stalls, the result waits in the output register and the
// back part holds a following result until the register is free.
// The user keeps configuration writes to idle; the block does not enforce this.
module matrix_product_checker import mpc_pkg::*; #(
	parameter int MAX_DIM    = MAX_DIM_DEF,
	parameter int ELEM_WIDTH = ELEM_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // row [3:0], col [7:4], value [23:8]
	input  logic [1:0]  s_tuser,   // command [1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // is_product [0], trials_done [7:1]
	input  logic        wr_en,
	input  logic [1:0]  wr_index,
	input  logic [31:0] wr_data
);

	localparam int EW = 2 + $clog2(MAX_DIM * MAX_DIM) + ELEM_WIDTH;

	logic [4:0]    size_q;
	logic [6:0]    trials_q;
	cfg_t          cfg;
	logic          q_full, push, pop, head_valid;
	logic [EW-1:0] push_data, head_data;
	logic          res_ok;
	logic [6:0]    res_cnt;

	// Register writes; a seed write also reloads the generator in the back part.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q   <= 5'd16;
			trials_q <= 7'd8;
		end else if (wr_en) begin
			if (wr_index == REG_SIZE) begin
				size_q <= wr_data[4:0];
			end
			if (wr_index == REG_TRIALS) begin
				trials_q <= wr_data[6:0];
			end
		end
	end

	// Out-of-range settings are clamped to the nearest legal value.
	always_comb begin
		priority if (size_q == 5'd0) begin
			cfg.dim = 7'd1;
		end else if (7'(size_q) > 7'(MAX_DIM)) begin
			cfg.dim = 7'(MAX_DIM);
		end else begin
			cfg.dim = 7'(size_q);
		end
		priority if (trials_q == 7'd0) begin
			cfg.trials = 7'd1;
		end else if (trials_q > 7'(MAX_TRIALS)) begin
			cfg.trials = 7'(MAX_TRIALS);
		end else begin
			cfg.trials = trials_q;
		end
		cfg.seed_we = wr_en && (wr_index == REG_SEED);
		cfg.seed    = wr_data;
	end

	mpc_front #(.MAX_DIM(MAX_DIM), .ELEM_WIDTH(ELEM_WIDTH), .EW(EW)) u_front (
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.s_tuser(s_tuser), .q_full(q_full), .push(push), .push_data(push_data)
	);

	mpc_queue #(.WIDTH(EW)) u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .push_data(push_data),
		.full(q_full), .pop(pop), .head_valid(head_valid), .head_data(head_data)
	);

	mpc_back #(.MAX_DIM(MAX_DIM), .ELEM_WIDTH(ELEM_WIDTH), .EW(EW)) u_back (
		.clk(clk), .arst_n(arst_n), .cfg(cfg), .q_valid(head_valid),
		.q_data(head_data), .q_pop(pop), .out_valid(m_tvalid),
		.out_ready(m_tready), .out_ok(res_ok), .out_cnt(res_cnt)
	);

	assign m_tdata = {res_cnt, res_ok};

endmodule

[rtl/core/mpc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mpc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[rtl/core/mpc_queue.sv]
// Two-entry queue between the front and back parts of the checker.
// No dependencies.
module mpc_queue #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic             head_valid,
	output logic [WIDTH-1:0] head_data
);

	logic [WIDTH-1:0] mem_q [2];
	logic             wp_q;
	logic             rp_q;
	logic [1:0]       cnt_q;

	assign full       = (cnt_q == 2'd2);
	assign head_valid = (cnt_q != 2'd0);
	assign head_data  = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (pop) begin
				rp_q <= ~rp_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= push_data;
		end
	end

endmodule

[rtl/core/mpc_front.sv]
// Front part: accepts input items, folds indexes into the matrix range,
// converts the element and queues one entry per item. Uses mpc_pkg.
module mpc_front import mpc_pkg::*; #(
	parameter int MAX_DIM    = MAX_DIM_DEF,
	parameter int ELEM_WIDTH = ELEM_WIDTH_DEF,
	parameter int EW         = 2 + $clog2(MAX_DIM * MAX_DIM) + ELEM_WIDTH
) (
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [23:0]   s_tdata,
	input  logic [1:0]    s_tuser,
	input  logic          q_full,
	output logic          push,
	output logic [EW-1:0] push_data
);

	localparam int AW = $clog2(MAX_DIM * MAX_DIM);

	// Remainder by MAX_DIM through repeated subtraction.
	function automatic logic [6:0] fold(input logic [3:0] v);
		logic [6:0] t;
		t = {3'd0, v};
		for (int k = 0; k < 8; k++) begin
			if (t >= 7'(MAX_DIM)) begin
				t = t - 7'(MAX_DIM);
			end
		end
		return t;
	endfunction

	logic [6:0]            row_m;
	logic [6:0]            col_m;
	logic [AW-1:0]         addr;
	logic [ELEM_WIDTH-1:0] elem;
	cmd_t                  kind;

	assign kind  = cmd_t'(s_tuser);
	assign row_m = fold(s_tdata[3:0]);
	assign col_m = fold(s_tdata[7:4]);
	assign addr  = AW'(row_m) * AW'(MAX_DIM) + AW'(col_m);
	assign elem  = ELEM_WIDTH'(signed'(s_tdata[23:8]));

	assign s_tready  = !q_full;
	assign push      = s_tvalid && !q_full;
	assign push_data = {elem, addr, kind};

endmodule

[rtl/core/mpc_back.sv]
// Back part: stores loaded elements and runs the randomized product check.
// Uses mpc_pkg, mpc_ram and the assertion macros.
`include "assert_macros.svh"
module mpc_back import mpc_pkg::*; #(
	parameter int MAX_DIM    = MAX_DIM_DEF,
	parameter int ELEM_WIDTH = ELEM_WIDTH_DEF,
	parameter int EW         = 2 + $clog2(MAX_DIM * MAX_DIM) + ELEM_WIDTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  cfg_t          cfg,
	input  logic          q_valid,
	input  logic [EW-1:0] q_data,
	output logic          q_pop,
	output logic          out_valid,
	input  logic          out_ready,
	output logic          out_ok,
	output logic [6:0]    out_cnt
);

	localparam int IW     = $clog2(MAX_DIM);
	localparam int AW     = $clog2(MAX_DIM * MAX_DIM);
	localparam int BR_W   = ELEM_WIDTH + IW;
	localparam int PROD_W = ELEM_WIDTH + BR_W;
	localparam int ACC_W  = PROD_W + IW;

	typedef enum logic [2:0] {
		S_IDLE, S_DRAW, S_BC, S_BC_WAIT, S_AX, S_AX_WAIT, S_TEND, S_FIN
	} state_t;

	state_t                state_q;
	logic [IW-1:0]         i_q, j_q;
	logic [31:0]           lfsr_q;
	logic [MAX_DIM-1:0]    r_q;
	logic [6:0]            passed_q;
	logic                  mismatch_q;
	logic                  out_valid_q, res_ok_q;
	logic [6:0]            res_cnt_q;

	cmd_t                  head_kind;
	logic [AW-1:0]         head_addr;
	logic [ELEM_WIDTH-1:0] head_elem;
	logic [IW-1:0]         n_last;
	logic                  j_last, i_last, issue;
	logic [AW-1:0]         rd_addr;

	logic                  v_s1_q, ax_s1_q, first_s1_q, last_s1_q;
	logic [IW-1:0]         i_s1_q, j_s1_q;
	logic                  v_s2_q, first_s2_q, last_s2_q;
	logic signed [PROD_W-1:0] prod_s2_q;
	logic [BR_W-1:0]       ct_s2_q;

	logic [ELEM_WIDTH-1:0] a_rd, b_rd, c_rd;
	logic [BR_W-1:0]       bt_rd, ct_rd;
	logic signed [BR_W-1:0] sb_q, sc_q, sb_next, sc_next;
	logic signed [ACC_W-1:0] acc_q, acc_next, cmp_val;
	logic                  mism_hit, br_we;

	assign head_kind = cmd_t'(q_data[1:0]);
	assign head_addr = q_data[AW+1:2];
	assign head_elem = q_data[EW-1:AW+2];
	assign q_pop     = (state_q == S_IDLE) && q_valid;

	assign n_last  = IW'(cfg.dim - 7'd1);
	assign j_last  = (j_q == n_last);
	assign i_last  = (i_q == n_last);
	assign issue   = (state_q == S_BC) || (state_q == S_AX);
	assign rd_addr = AW'(i_q) * AW'(MAX_DIM) + AW'(j_q);

	mpc_ram #(.WIDTH(ELEM_WIDTH), .DEPTH(MAX_DIM * MAX_DIM)) u_ram_a (
		.clk(clk), .we(q_pop && head_kind == CMD_LOAD_A), .waddr(head_addr),
		.wdata(head_elem), .raddr(rd_addr), .rdata(a_rd)
	);
	mpc_ram #(.WIDTH(ELEM_WIDTH), .DEPTH(MAX_DIM * MAX_DIM)) u_ram_b (
		.clk(clk), .we(q_pop && head_kind == CMD_LOAD_B), .waddr(head_addr),
		.wdata(head_elem), .raddr(rd_addr), .rdata(b_rd)
	);
	mpc_ram #(.WIDTH(ELEM_WIDTH), .DEPTH(MAX_DIM * MAX_DIM)) u_ram_c (
		.clk(clk), .we(q_pop && head_kind == CMD_LOAD_C), .waddr(head_addr),
		.wdata(head_elem), .raddr(rd_addr), .rdata(c_rd)
	);

	// Row sums of B*r and C*r, one entry per row.
	assign br_we = v_s1_q && !ax_s1_q && last_s1_q;

	mpc_ram #(.WIDTH(BR_W), .DEPTH(MAX_DIM)) u_ram_bt (
		.clk(clk), .we(br_we), .waddr(i_s1_q), .wdata(sb_next),
		.raddr(j_q), .rdata(bt_rd)
	);
	mpc_ram #(.WIDTH(BR_W), .DEPTH(MAX_DIM)) u_ram_ct (
		.clk(clk), .we(br_we), .waddr(i_s1_q), .wdata(sc_next),
		.raddr(i_q), .rdata(ct_rd)
	);

	always_comb begin
		sb_next = first_s1_q ? '0 : sb_q;
		sc_next = first_s1_q ? '0 : sc_q;
		if (r_q[j_s1_q]) begin
			sb_next = sb_next + BR_W'(signed'(b_rd));
			sc_next = sc_next + BR_W'(signed'(c_rd));
		end
	end

	assign acc_next = (first_s2_q ? '0 : acc_q) + ACC_W'(prod_s2_q);
	assign cmp_val  = ACC_W'(signed'(ct_s2_q)) <<< FRAC_BITS;
	assign mism_hit = v_s2_q && last_s2_q && (acc_next != cmp_val);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1_q <= 1'b0;
			v_s2_q <= 1'b0;
		end else begin
			v_s1_q <= issue;
			v_s2_q <= v_s1_q && ax_s1_q;
		end
	end

	always_ff @(posedge clk) begin
		ax_s1_q    <= (state_q == S_AX);
		first_s1_q <= (j_q == '0);
		last_s1_q  <= j_last;
		i_s1_q     <= i_q;
		j_s1_q     <= j_q;
		first_s2_q <= first_s1_q;
		last_s2_q  <= last_s1_q;
		prod_s2_q  <= PROD_W'(signed'(a_rd)) * PROD_W'(signed'(bt_rd));
		ct_s2_q    <= ct_rd;
		if (v_s1_q && !ax_s1_q) begin
			sb_q <= sb_next;
			sc_q <= sc_next;
		end
		if (v_s2_q) begin
			acc_q <= acc_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			i_q         <= '0;
			j_q         <= '0;
			lfsr_q      <= 32'd1;
			passed_q    <= 7'd0;
			mismatch_q  <= 1'b0;
			out_valid_q <= 1'b0;
			res_ok_q    <= 1'b0;
			res_cnt_q   <= 7'd0;
		end else begin
			if (cfg.seed_we) begin
				lfsr_q <= (cfg.seed == 32'd0) ? 32'd1 : cfg.seed;
			end
			// In the finish state the output register is handled below.
			if (out_valid_q && out_ready && (state_q != S_FIN)) begin
				out_valid_q <= 1'b0;
			end
			if (mism_hit) begin
				mismatch_q <= 1'b1;
			end
			unique case (state_q)
				S_IDLE: begin
					if (q_valid && head_kind == CMD_CHECK) begin
						passed_q   <= 7'd0;
						mismatch_q <= 1'b0;
						j_q        <= '0;
						state_q    <= S_DRAW;
					end
				end
				S_DRAW: begin
					r_q[j_q] <= lfsr_q[0];
					lfsr_q   <= (lfsr_q >> 1) ^ (lfsr_q[0] ? LFSR_TAPS : 32'd0);
					if (j_last) begin
						j_q     <= '0;
						i_q     <= '0;
						state_q <= S_BC;
					end else begin
						j_q <= j_q + 1'b1;
					end
				end
				S_BC, S_AX: begin
					if (j_last) begin
						j_q <= '0;
						if (i_last) begin
							i_q     <= '0;
							state_q <= (state_q == S_BC) ? S_BC_WAIT : S_AX_WAIT;
						end else begin
							i_q <= i_q + 1'b1;
						end
					end else begin
						j_q <= j_q + 1'b1;
					end
				end
				S_BC_WAIT: begin
					if (!v_s1_q) begin
						state_q <= S_AX;
					end
				end
				S_AX_WAIT: begin
					if (!v_s1_q && !v_s2_q) begin
						state_q <= S_TEND;
					end
				end
				S_TEND: begin
					if (mismatch_q) begin
						state_q <= S_FIN;
					end else if (passed_q + 7'd1 == cfg.trials) begin
						state_q <= S_FIN;
					end else begin
						passed_q <= passed_q + 7'd1;
						j_q      <= '0;
						state_q  <= S_DRAW;
					end
				end
				S_FIN: begin
					// The result only enters the output register once it is free.
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						res_ok_q    <= !mismatch_q;
						res_cnt_q   <= mismatch_q ? passed_q : passed_q + 7'd1;
						state_q     <= S_IDLE;
					end
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_ok    = res_ok_q;
	assign out_cnt   = res_cnt_q;

	`ASSERT_AT(a_idle_drained, clk, arst_n, (state_q == S_IDLE) |-> (!v_s1_q && !v_s2_q), "pipeline busy while idle")
	`ASSERT_AT(a_result_from_fin, clk, arst_n, (!out_valid_q ##1 out_valid_q) |-> $past(state_q == S_FIN), "result raised outside finish")
	`ASSERT_NEVER(a_passed_range, clk, arst_n, (state_q != S_IDLE) && (passed_q >= cfg.trials), "pass count reached total while running")
	`ASSERT_AT(a_mismatch_src, clk, arst_n, $rose(mismatch_q) |-> $past(v_s2_q && last_s2_q), "mismatch set outside a row end")

endmodule

[test/mpc_check_monitor.sv]
// Passive checker for the matrix product checker: watches the configuration port and
// both streams, predicts each check result and compares it. Depends on mpc_pkg only.
module mpc_check_monitor import mpc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [23:0] s_tdata,   // row [3:0], col [7:4], value [23:8]
	input  logic [1:0]  s_tuser,   // command [1:0]
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [7:0]  m_tdata,   // is_product [0], trials_done [7:1]
	input  logic        wr_en,
	input  logic [1:0]  wr_index,
	input  logic [31:0] wr_data,
	output int          mismatches,
	output int          outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [6:0] trials_done;
		logic       is_product;
	} verdict_t;

	logic signed [15:0] mat_a [16][16];
	logic signed [15:0] mat_b [16][16];
	logic signed [15:0] mat_c [16][16];
	logic [4:0]  size_reg;
	logic [6:0]  trials_reg;
	logic [31:0] lfsr;
	verdict_t    verdicts [$];

	// Runs the Freivalds trials on the mirrored stores and advances the generator.
	function automatic verdict_t freivalds_verdict();
		int n, total;
		bit r [16];
		bit bad;
		longint bsum [16];
		longint csum [16];
		longint acc;
		verdict_t v;
		n = (size_reg == 0) ? 1 : (size_reg > 16) ? 16 : size_reg;
		total = (trials_reg == 0) ? 1 : (trials_reg > MAX_TRIALS) ? MAX_TRIALS : trials_reg;
		v.is_product = 1'b1;
		v.trials_done = '0;
		for (int t = 0; t < total; t++) begin
			for (int j = 0; j < n; j++) begin
				r[j] = lfsr[0];
				lfsr = lfsr >> 1;
				if (r[j])
					lfsr = lfsr ^ LFSR_TAPS;
			end
			for (int i = 0; i < n; i++) begin
				bsum[i] = 0;
				csum[i] = 0;
				for (int j = 0; j < n; j++)
					if (r[j]) begin
						bsum[i] += longint'(mat_b[i][j]);
						csum[i] += longint'(mat_c[i][j]);
					end
			end
			bad = 0;
			for (int i = 0; i < n; i++) begin
				acc = 0;
				for (int j = 0; j < n; j++)
					acc += longint'(mat_a[i][j]) * bsum[j];
				// A*(B*r) has twice the fraction bits, so align C*r before comparing.
				if (acc != (csum[i] <<< FRAC_BITS))
					bad = 1;
			end
			if (bad) begin
				v.is_product = 1'b0;
				break;
			end
			v.trials_done++;
		end
		return v;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		verdict_t want, got;
		if (!arst_n) begin
			size_reg = 5'd16;
			trials_reg = 7'd8;
			lfsr = 32'd1;
			verdicts.delete();
			mismatches = 0;
			outstanding = 0;
		end else begin
			if (wr_en) begin
				case (wr_index)
					REG_SIZE:   size_reg = wr_data[4:0];
					REG_TRIALS: trials_reg = wr_data[6:0];
					REG_SEED:   lfsr = (wr_data == 0) ? 32'd1 : wr_data;
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				case (cmd_t'(s_tuser))
					CMD_LOAD_A: mat_a[s_tdata[3:0]][s_tdata[7:4]] = s_tdata[23:8];
					CMD_LOAD_B: mat_b[s_tdata[3:0]][s_tdata[7:4]] = s_tdata[23:8];
					CMD_LOAD_C: mat_c[s_tdata[3:0]][s_tdata[7:4]] = s_tdata[23:8];
					CMD_CHECK:  verdicts.push_back(freivalds_verdict());
				endcase
			end
			if (m_tvalid && m_tready) begin
				got = m_tdata;
				if (verdicts.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
					mismatches++;
				end else begin
					want = verdicts.pop_front();
					if (got.is_product !== want.is_product) begin
						$display("%0t: is_product expected %0d actual %0d", $time,
							want.is_product, got.is_product);
						mismatches++;
					end
					if (got.trials_done !== want.trials_done) begin
						$display("%0t: trials_done expected %0d actual %0d", $time,
							want.trials_done, got.trials_done);
						mismatches++;
					end
				end
			end
			outstanding = verdicts.size();
		end
	end

endmodule

[test/tb_matrix_product_checker.sv]
// Top of the matrix product checker testbench: clock, reset, stimulus and verdict.
// Depends on mpc_pkg, matrix_product_checker and mpc_check_monitor.
module tb_matrix_product_checker import mpc_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	// Index three names no register; a write to it must change nothing.
	localparam logic [1:0] REG_UNUSED = 2'd3;
	localparam int ITEM_TARGET = 1150;
	localparam int CYCLE_LIMIT = 4_000_000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;
	logic        wr_en = 1'b0;
	logic [1:0]  wr_index = '0;
	logic [31:0] wr_data = '0;

	int mismatches, outstanding;
	int items_sent = 0;
	int checks_sent = 0;
	int results_seen = 0;
	int cycles = 0;
	int filled_dim = 0;
	bit hold_req = 1'b0;
	bit hold_active = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	matrix_product_checker u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
	);

	mpc_check_monitor u_monitor (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
		.mismatches(mismatches), .outstanding(outstanding)
	);

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycles++;
		if (m_tvalid && m_tready)
			results_seen++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Result side. Ready alternates between stretches of always ready, random ready
	// and short stalls. Once, when the stimulus asks for it, it holds off for a long
	// time while the sender keeps going, so the queue fills and the input is
	// back-pressured.
	initial begin
		int mode, span;
		forever begin
			mode = $urandom_range(0, 9);
			span = $urandom_range(20, 150);
			if (!hold_active && hold_req) begin
				m_tready <= 1'b0;
				hold_active = 1'b1;
				repeat (400) @(posedge clk);
			end else if (mode < 3) begin
				m_tready <= 1'b1;
				repeat (span) @(posedge clk);
			end else if (mode == 9) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(10, 50)) @(posedge clk);
			end else begin
				repeat (span) begin
					m_tready <= ($urandom_range(0, 3) != 0);
					@(posedge clk);
				end
			end
		end
	end

	// Clamp a size setting the way the block does, for planning the stimulus.
	function automatic int dim_of(int s);
		return (s == 0) ? 1 : (s > 16) ? 16 : s;
	endfunction

	// Offers one item after a random gap and waits until it is taken. Valid stays
	// high afterwards, so back-to-back items never drop it within a step.
	task automatic send_item(cmd_t c, int row, int col, logic [15:0] value);
		int pick, gap;
		pick = $urandom_range(0, 9);
		gap = (pick < 6) ? 0 : (pick < 9) ? $urandom_range(1, 3) : $urandom_range(10, 40);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= c;
		s_tdata <= {value, col[3:0], row[3:0]};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		items_sent++;
		if (c == CMD_CHECK)
			checks_sent++;
	endtask

	task automatic send_check();
		send_item(CMD_CHECK, $urandom_range(0, 15), $urandom_range(0, 15), 16'($urandom()));
	endtask

	// Settings change only while the block is idle: every result back, and a further
	// wait so that a trailing load has left the queue.
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic configure(int size, int trials, bit load_seed, logic [31:0] seed);
		wr_en <= 1'b1;
		wr_index <= REG_SIZE;
		wr_data <= size;
		@(posedge clk);
		wr_index <= REG_TRIALS;
		wr_data <= trials;
		@(posedge clk);
		if (load_seed) begin
			wr_index <= REG_SEED;
			wr_data <= seed;
			@(posedge clk);
		end
		if ($urandom_range(0, 4) == 0) begin
			wr_index <= REG_UNUSED;
			wr_data <= $urandom();
			@(posedge clk);
		end
		wr_en <= 1'b0;
		@(posedge clk);
	endtask

	// Loads a consistent triple: A holds whole numbers, so A*B lands back in Q8.8
	// exactly and C can be made its true product. Optionally one C element is
	// disturbed so the check should catch it (unless no drawn vector exposes it).
	task automatic load_product(int n, bit corrupt);
		int ka [16][16];
		int mb [16][16];
		int mc;
		int bad_r, bad_c;
		for (int i = 0; i < n; i++)
			for (int j = 0; j < n; j++) begin
				ka[i][j] = $urandom_range(0, 6) - 3;
				mb[i][j] = $urandom_range(0, 1200) - 600;
			end
		bad_r = $urandom_range(0, n - 1);
		bad_c = $urandom_range(0, n - 1);
		for (int i = 0; i < n; i++)
			for (int k = 0; k < n; k++) begin
				mc = 0;
				for (int j = 0; j < n; j++)
					mc += ka[i][j] * mb[j][k];
				if (corrupt && i == bad_r && k == bad_c)
					mc += $urandom_range(1, 50);
				send_item(CMD_LOAD_A, i, k, 16'(ka[i][k] * 256));
				send_item(CMD_LOAD_B, i, k, 16'(mb[i][k]));
				send_item(CMD_LOAD_C, i, k, 16'(mc));
			end
		if (n > filled_dim)
			filled_dim = n;
	endtask

	initial begin
		int size, trials, n, pick, ops;
		bit big_done;
		big_done = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: a 1x1 problem with the most extreme elements and a zero seed,
		// which must behave like seed 1. Loads outside the size are stored but unused.
		configure(1, 1, 1, 32'd0);
		send_item(CMD_LOAD_A, 0, 0, 16'h7FFF);
		send_item(CMD_LOAD_B, 0, 0, 16'h8000);
		send_item(CMD_LOAD_C, 0, 0, 16'h8000);
		send_item(CMD_LOAD_A, 15, 15, 16'hFFFF);
		send_check();
		send_item(CMD_LOAD_A, 0, 0, 16'h8000);
		send_item(CMD_LOAD_C, 0, 0, 16'h0000);
		send_check();
		filled_dim = 1;
		wait_idle();
		// Zero trials counts as one; a 2x2 product that should hold.
		configure(2, 0, 1, 32'hFFFF_FFFF);
		load_product(2, 0);
		send_check();
		wait_idle();
		// Zero size counts as one; oversized trials clamp to the maximum.
		configure(0, 127, 0, 32'd0);
		send_check();
		wait_idle();

		// Back-pressure: the receiver holds off while two short checks and a run
		// of loads outside the size are offered, so the result register, the back
		// part and the queue all fill and the input stalls.
		configure(1, 1, 0, 32'd0);
		hold_req = 1'b1;
		wait (hold_active);
		@(posedge clk);
		send_check();
		send_check();
		repeat (10)
			send_item(cmd_t'($urandom_range(0, 2)), 15, 15, 16'($urandom()));
		wait_idle();

		// Random phases: each picks settings, reloads a consistent triple half the time
		// (always when the size grows past what has been written), then mixes
		// stray loads with checks.
		while (items_sent < ITEM_TARGET) begin
			wait_idle();
			if (!big_done && items_sent > 500) begin
				// The largest problem with the most trials, once.
				configure(16, 64, 1, $urandom());
				load_product(16, 0);
				send_check();
				wait_idle();
				configure(25, 3, 0, 32'd0);
				send_check();
				big_done = 1;
				continue;
			end
			pick = $urandom_range(0, 19);
			if (pick < 14)
				size = $urandom_range(1, 5);
			else if (pick < 17)
				size = $urandom_range(6, 15);
			else if (pick < 19)
				size = (pick == 17) ? 0 : $urandom_range(17, 31);
			else
				size = 16;
			n = dim_of(size);
			if (n > 8 && !big_done) begin
				n = $urandom_range(6, 8);
				size = n;
			end
			pick = $urandom_range(0, 9);
			if (pick < 6 || n > 8)
				trials = $urandom_range(1, 8);
			else if (pick < 8)
				trials = $urandom_range(9, 64);
			else
				trials = (pick == 8) ? 0 : $urandom_range(65, 127);
			configure(size, trials, 1'($urandom_range(0, 1)),
				($urandom_range(0, 7) == 0) ? 32'd0 : $urandom());
			if (n > filled_dim || $urandom_range(0, 1)) begin
				load_product(n, $urandom_range(0, 2) == 0);
				send_check();
			end
			ops = $urandom_range(2, 8);
			repeat (ops) begin
				if ($urandom_range(0, 9) < 7)
					send_item(cmd_t'($urandom_range(0, 2)), $urandom_range(0, 15),
						$urandom_range(0, 15), 16'($urandom()));
				else
					send_check();
			end
		end

		wait_idle();
		repeat (50) @(posedge clk);
		$display("Covered %0d items with %0d checks and %0d results,", items_sent,
			checks_sent, results_seen);
		$display("sizes 1 to 16 and clamped settings, under random gaps and stalls.");
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
